/* hdl/dtyp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtyp_pkg
// shared constants, arctangent table and sideband type of the direction to
// yaw/pitch converter
// ----------------------------------------------------------------------------
package dtyp_pkg;

    localparam int COMPONENT_BITS_DEF  = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // angle accumulator, Q.30 radians
    localparam int ACC_FRAC = 30;
    localparam int STEPS    = 31;
    localparam int ZW       = 34;
    localparam int GUARD    = 16;

    localparam logic signed [ZW-1:0] PI_ACC = 34'sd3373259426;

    // atan(2^-i) * 2^30, truncated up to i = 26, rounded from i = 27
    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // flags that ride along with a word through the cell row
    typedef struct packed {
        logic valid;
        logic yaw_zero;   // x and y both zero
        logic x_neg;
        logic y_neg;
        logic y_pos;
        logic z_pos;
        logic pitch_zero; // y and z both zero
    } t_side;

endpackage

/* hdl/dtyp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtyp_in_if / dtyp_out_if
// valid/ready channels for direction words and angle words
// ----------------------------------------------------------------------------
interface dtyp_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface dtyp_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] yaw_angle;
    logic signed [W-1:0] pitch_angle;
    modport source (output valid, output yaw_angle, output pitch_angle, input ready);
    modport sink   (input valid, input yaw_angle, input pitch_angle, output ready);
endinterface

/* hdl/dtyp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtyp_cell
// one cordic vectoring step for the yaw and pitch lanes, registered
// ----------------------------------------------------------------------------
module dtyp_cell #(
    parameter int STEP = 0,
    parameter int DW   = 35
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  dtyp_pkg::t_side             i_side,
    input  logic signed [DW-1:0]        i_yx,
    input  logic signed [DW-1:0]        i_yy,
    input  logic signed [dtyp_pkg::ZW-1:0] i_yz,
    input  logic signed [DW-1:0]        i_px,
    input  logic signed [DW-1:0]        i_py,
    input  logic signed [dtyp_pkg::ZW-1:0] i_pz,
    output dtyp_pkg::t_side             o_side,
    output logic signed [DW-1:0]        o_yx,
    output logic signed [DW-1:0]        o_yy,
    output logic signed [dtyp_pkg::ZW-1:0] o_yz,
    output logic signed [DW-1:0]        o_px,
    output logic signed [DW-1:0]        o_py,
    output logic signed [dtyp_pkg::ZW-1:0] o_pz
);
    import dtyp_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_tab(STEP);

    logic signed [DW-1:0] n_yx, n_yy, n_px, n_py;
    logic signed [ZW-1:0] n_yz, n_pz;

    always_comb begin
        if (i_yy > 0) begin
            n_yx = i_yx + (i_yy >>> STEP);
            n_yy = i_yy - (i_yx >>> STEP);
            n_yz = i_yz + ATAN;
        end else begin
            n_yx = i_yx - (i_yy >>> STEP);
            n_yy = i_yy + (i_yx >>> STEP);
            n_yz = i_yz - ATAN;
        end
        if (i_py > 0) begin
            n_px = i_px + (i_py >>> STEP);
            n_py = i_py - (i_px >>> STEP);
            n_pz = i_pz + ATAN;
        end else begin
            n_px = i_px - (i_py >>> STEP);
            n_py = i_py + (i_px >>> STEP);
            n_pz = i_pz - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side.valid <= 1'b0;
        end else if (i_en) begin
            o_side.valid <= i_side.valid;
        end
        if (i_en) begin
            o_side.yaw_zero   <= i_side.yaw_zero;
            o_side.x_neg      <= i_side.x_neg;
            o_side.y_neg      <= i_side.y_neg;
            o_side.y_pos      <= i_side.y_pos;
            o_side.z_pos      <= i_side.z_pos;
            o_side.pitch_zero <= i_side.pitch_zero;
            o_yx <= n_yx;
            o_yy <= n_yy;
            o_yz <= n_yz;
            o_px <= n_px;
            o_py <= n_py;
            o_pz <= n_pz;
        end
    end

endmodule

/* hdl/dtyp_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtyp_finish
// quadrant fix-up, sign selection and rounding to the output format
// ----------------------------------------------------------------------------
module dtyp_finish #(
    parameter int AW  = 16,
    parameter int AFB = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  dtyp_pkg::t_side                i_side,
    input  logic signed [dtyp_pkg::ZW-1:0] i_yz,
    input  logic signed [dtyp_pkg::ZW-1:0] i_pz,
    output logic                           o_valid,
    output logic signed [AW-1:0]           o_yaw,
    output logic signed [AW-1:0]           o_pitch
);
    import dtyp_pkg::*;

    localparam int SH = ACC_FRAC - AFB;
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sd1 <<< (SH - 1));

    logic                 r_valid1;
    logic signed [ZW-1:0] r_yaw1, r_pitch1;
    logic signed [ZW-1:0] n_yaw1, n_pitch1, yaw_a, pitch_c;

    function automatic logic signed [AW-1:0] round_out(input logic signed [ZW-1:0] t);
        logic signed [ZW-1:0] m;
        logic signed [ZW-1:0] r;
        m = (t < 0) ? -t : t;
        r = (m + HALF) >>> SH;
        if (t < 0) r = -r;
        return r[AW-1:0];
    endfunction

    always_comb begin
        yaw_a   = i_side.y_neg ? PI_ACC - i_yz : i_yz;
        pitch_c = i_side.y_neg ? PI_ACC - i_pz : i_pz;
        if (i_side.yaw_zero) begin
            n_yaw1 = '0;
        end else begin
            n_yaw1 = i_side.x_neg ? yaw_a : -yaw_a;
        end
        if (i_side.pitch_zero) begin
            n_pitch1 = '0;
        end else if (i_side.y_pos) begin
            n_pitch1 = i_side.z_pos ? pitch_c : -pitch_c;
        end else begin
            n_pitch1 = i_side.z_pos ? PI_ACC - pitch_c : pitch_c - PI_ACC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_side.valid;
            o_valid  <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yaw1   <= n_yaw1;
            r_pitch1 <= n_pitch1;
            o_yaw    <= round_out(r_yaw1);
            o_pitch  <= round_out(r_pitch1);
        end
    end

endmodule

/* hdl/direction_to_yaw_pitch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_to_yaw_pitch
// direction vector to yaw and pitch angles through a row of cordic cells
// ----------------------------------------------------------------------------
// channel | dir | words
// i_in    | in  | dir_x, dir_y, dir_z
// o_out   | out | yaw_angle, pitch_angle
//
// one word per cycle while the skid register is empty; the path is the 31 cell row
// plus input, fix-up, rounding and output registers
// synchronous active-low reset clears all valid flags
// a stalled output parks one word in a skid register; the row holds while full
// ----------------------------------------------------------------------------
module direction_to_yaw_pitch #(
    parameter int COMPONENT_BITS  = dtyp_pkg::COMPONENT_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = dtyp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtyp_in_if.sink    i_in,
    dtyp_out_if.source o_out
);
    import dtyp_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int DW = COMPONENT_BITS + GUARD + 3;
    localparam int AW = ANGLE_FRAC_BITS + 3;

    logic en;
    logic r_skid_valid;
    logic signed [AW-1:0] r_skid_yaw, r_skid_pitch;
    logic r_out_valid;
    logic signed [AW-1:0] r_out_yaw, r_out_pitch;

    t_side                s_side [0:STEPS];
    logic signed [DW-1:0] s_yx [0:STEPS];
    logic signed [DW-1:0] s_yy [0:STEPS];
    logic signed [ZW-1:0] s_yz [0:STEPS];
    logic signed [DW-1:0] s_px [0:STEPS];
    logic signed [DW-1:0] s_py [0:STEPS];
    logic signed [ZW-1:0] s_pz [0:STEPS];

    logic signed [DW-1:0] ex, ey, ez, ax, ay, az;
    t_side                n_side;

    logic                 f_valid;
    logic signed [AW-1:0] f_yaw, f_pitch;
    logic                 load_ok;

    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    always_comb begin
        ex = DW'(i_in.dir_x);
        ey = DW'(i_in.dir_y);
        ez = DW'(i_in.dir_z);
        ax = ex[DW-1] ? -ex : ex;
        ay = ey[DW-1] ? -ey : ey;
        az = ez[DW-1] ? -ez : ez;
        n_side.valid      = i_in.valid;
        n_side.yaw_zero   = (i_in.dir_x == '0) && (i_in.dir_y == '0);
        n_side.pitch_zero = (i_in.dir_y == '0) && (i_in.dir_z == '0);
        n_side.x_neg      = i_in.dir_x[CB-1];
        n_side.y_neg      = i_in.dir_y[CB-1];
        n_side.y_pos      = !i_in.dir_y[CB-1] && (i_in.dir_y != '0);
        n_side.z_pos      = !i_in.dir_z[CB-1] && (i_in.dir_z != '0);
    end

    // input register: mirrored, scaled magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_side[0].valid <= 1'b0;
        end else if (en) begin
            s_side[0].valid <= n_side.valid;
        end
        if (en) begin
            s_side[0].yaw_zero   <= n_side.yaw_zero;
            s_side[0].pitch_zero <= n_side.pitch_zero;
            s_side[0].x_neg      <= n_side.x_neg;
            s_side[0].y_neg      <= n_side.y_neg;
            s_side[0].y_pos      <= n_side.y_pos;
            s_side[0].z_pos      <= n_side.z_pos;
            s_yx[0] <= ay <<< GUARD;
            s_yy[0] <= ax <<< GUARD;
            s_yz[0] <= '0;
            s_px[0] <= ay <<< GUARD;
            s_py[0] <= az <<< GUARD;
            s_pz[0] <= '0;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        dtyp_cell #(.STEP(g), .DW(DW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_side (s_side[g]),
            .i_yx   (s_yx[g]),
            .i_yy   (s_yy[g]),
            .i_yz   (s_yz[g]),
            .i_px   (s_px[g]),
            .i_py   (s_py[g]),
            .i_pz   (s_pz[g]),
            .o_side (s_side[g+1]),
            .o_yx   (s_yx[g+1]),
            .o_yy   (s_yy[g+1]),
            .o_yz   (s_yz[g+1]),
            .o_px   (s_px[g+1]),
            .o_py   (s_py[g+1]),
            .o_pz   (s_pz[g+1])
        );
    end

    dtyp_finish #(.AW(AW), .AFB(ANGLE_FRAC_BITS)) u_finish (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (s_side[STEPS]),
        .i_yz   (s_yz[STEPS]),
        .i_pz   (s_pz[STEPS]),
        .o_valid(f_valid),
        .o_yaw  (f_yaw),
        .o_pitch(f_pitch)
    );

    assign load_ok = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (load_ok) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (f_valid) begin
            if (load_ok) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (load_ok) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (load_ok) begin
                r_out_yaw   <= r_skid_yaw;
                r_out_pitch <= r_skid_pitch;
            end
        end else if (f_valid) begin
            if (load_ok) begin
                r_out_yaw   <= f_yaw;
                r_out_pitch <= f_pitch;
            end else begin
                r_skid_yaw   <= f_yaw;
                r_skid_pitch <= f_pitch;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.yaw_angle   = r_out_yaw;
    assign o_out.pitch_angle = r_out_pitch;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_out.ready))
        else $error("skid filled while output was free");

    a_skid_refills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_out.ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid word lost on drain");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives direction words into the yaw/pitch converter and checks every
// angle word against a bit-exact cordic predictor kept in a scoreboard class
// ----------------------------------------------------------------------------
module tb_top;
    import dtyp_pkg::*;

    localparam int CW = 16;
    localparam int AW = 16;
    localparam int N_RANDOM = 1600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dtyp_in_if  #(.W(CW)) in_ch ();
    dtyp_out_if #(.W(AW)) out_ch ();

    direction_to_yaw_pitch #(.COMPONENT_BITS(CW), .ANGLE_FRAC_BITS(13)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    typedef struct packed {
        logic signed [AW-1:0] yaw;
        logic signed [AW-1:0] pitch;
    } t_angles;

    int n_errors = 0;

    function automatic void report_mismatch(input string what, input int got, input int want);
        $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endfunction

    class angle_scoreboard;
        t_angles pending[$];
        int n_checked = 0;

        // angle of (px, py), both non-negative, Q.30
        function automatic longint cordic_angle(longint px, longint py);
            longint xa, ya, za, dx, dy;
            xa = px * 65536;
            ya = py * 65536;
            za = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = ya >>> i;
                dy = xa >>> i;
                if (ya > 0) begin
                    xa += dx; ya -= dy; za += longint'(atan_tab(i));
                end else begin
                    xa -= dx; ya += dy; za -= longint'(atan_tab(i));
                end
            end
            return za;
        endfunction

        function automatic longint half_turn(longint lat, longint refc);
            if (refc >= 0) return cordic_angle(refc, lat);
            return longint'(PI_ACC) - cordic_angle(-refc, lat);
        endfunction

        function automatic logic [AW-1:0] round_angle(longint t);
            longint m, r;
            m = (t < 0) ? -t : t;
            r = (m + (64'sd1 <<< 16)) >>> 17;
            if (t < 0) r = -r;
            return r[AW-1:0];
        endfunction

        function void note_direction(logic signed [CW-1:0] dx, logic signed [CW-1:0] dy,
                                     logic signed [CW-1:0] dz);
            longint x, y, z, a, c, yaw, pitch;
            t_angles e;
            x = dx; y = dy; z = dz;
            yaw = 0; pitch = 0;
            if (x != 0 || y != 0) begin
                a = half_turn((x < 0) ? -x : x, y);
                yaw = (x < 0) ? a : -a;
            end
            if (y != 0 || z != 0) begin
                c = half_turn((z < 0) ? -z : z, y);
                if (y > 0) pitch = (z > 0) ? c : -c;
                else pitch = (z > 0) ? (longint'(PI_ACC) - c) : (c - longint'(PI_ACC));
            end
            e.yaw = round_angle(yaw);
            e.pitch = round_angle(pitch);
            pending.push_back(e);
        endfunction

        function void check_angles(logic signed [AW-1:0] yaw, logic signed [AW-1:0] pitch);
            t_angles e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word yaw", yaw, 0);
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (yaw !== e.yaw) report_mismatch("yaw_angle", yaw, e.yaw);
            if (pitch !== e.pitch) report_mismatch("pitch_angle", pitch, e.pitch);
        endfunction
    endclass

    angle_scoreboard sb = new();

    bit quiet_phase = 1'b0;
    bit hold_off = 1'b0;
    int n_sent = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.dir_x = '0;
        in_ch.dir_y = '0;
        in_ch.dir_z = '0;
        out_ch.ready = 1'b0;
    end

    // monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_direction(in_ch.dir_x, in_ch.dir_y, in_ch.dir_z);
            if (out_ch.valid && out_ch.ready)
                sb.check_angles(out_ch.yaw_angle, out_ch.pitch_angle);
        end
    end

    // receiver: random stall bursts, plus one long hold-off
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_direction(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                  input logic [CW-1:0] z);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.dir_x <= x;
        in_ch.dir_y <= y;
        in_ch.dir_z <= z;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    function automatic logic [CW-1:0] pick_component();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return CW'($urandom_range(0, 6)) - 16'd3;
            default: return CW'($urandom);
        endcase
    endfunction

    localparam logic [CW-1:0] MIN_C = 16'h8000;
    localparam logic [CW-1:0] MAX_C = 16'h7fff;

    initial begin
        logic [CW-1:0] xs [12];
        logic [CW-1:0] ys [12];
        logic [CW-1:0] zs [12];
        int tail;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all zero, zero pairs, extremes, sign quadrants
        xs = '{16'd0, 16'd0, 16'd5, MIN_C, MAX_C, MIN_C, 16'd0, MAX_C, 16'hffff, 16'd1,
               16'd7, 16'hfff9};
        ys = '{16'd0, 16'd0, 16'd0, MIN_C, MAX_C, MAX_C, MIN_C, 16'd0, 16'hffff, 16'd1,
               16'hfff0, 16'd16};
        zs = '{16'd0, 16'd9, 16'd0, MIN_C, MAX_C, MIN_C, 16'd0, MIN_C, 16'd1, 16'hffff,
               16'd3, 16'hfffd};
        for (int i = 0; i < 12; i++) send_direction(xs[i], ys[i], zs[i]);
        send_direction(16'd0, MAX_C, 16'd0);
        send_direction(16'd0, MIN_C, 16'd5);
        send_direction(16'd100, 16'd100, 16'hff9c);
        send_direction(16'hff9c, 16'hff9c, 16'd100);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 400) hold_off = 1'b1;
            if (i == 1300) quiet_phase = 1'b1;
            send_direction(pick_component(), pick_component(), pick_component());
        end
        in_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        tail = 0;
        while (tail < 50) begin
            @(posedge i_clk);
            tail++;
        end
        $display("sent %0d direction words, checked %0d angle words", n_sent, sb.n_checked);
        $display("covered zero pairs, full-scale components, all sign quadrants, backpressure");
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // long receiver hold-off, counted in cycles, so the row fills and stalls input
    initial begin
        int held;
        wait (hold_off);
        held = 0;
        while (held < 120) begin
            @(posedge i_clk);
            held++;
        end
        hold_off = 1'b0;
    end

    initial begin
        #500000;
        $display("timeout waiting for angle words");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* direction_to_yaw_pitch.f */
hdl/dtyp_pkg.sv
hdl/dtyp_if.sv
hdl/dtyp_cell.sv
hdl/dtyp_finish.sv
hdl/direction_to_yaw_pitch.sv
dv/tb_top.sv
